### sv/tpg_pkg.sv
// Shared types and constants for the turtle plotter grid block.
package tpg_pkg;

   // Command kinds carried on the request tuser.
   typedef enum logic [2:0] {
      KIND_PEN_UP     = 3'd0,
      KIND_PEN_DOWN   = 3'd1,
      KIND_TURN_RIGHT = 3'd2,
      KIND_TURN_LEFT  = 3'd3,
      KIND_MOVE       = 3'd4,
      KIND_DISPLAY    = 3'd5
   } kind_type;

   // Heading codes, clockwise from east.
   localparam logic [1:0] HEAD_EAST  = 2'd0;
   localparam logic [1:0] HEAD_SOUTH = 2'd1;
   localparam logic [1:0] HEAD_WEST  = 2'd2;
   localparam logic [1:0] HEAD_NORTH = 2'd3;

   // Result and request item field widths.
   localparam int ROW_BITS_W = 20;
   localparam int POS_W      = 5;
   localparam int RSP_PAD_W  = 2;
   localparam int RSP_DATA_W = 40;
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 3;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RESP,
      ST_MV_READ,
      ST_MV_STEP,
      ST_DISP
   } state_type;

   // Grid read address sources.
   typedef enum logic [1:0] {
      RD_ZERO,
      RD_CUR,
      RD_NEXT,
      RD_DISP_NEXT
   } rd_sel_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic       pen_set;
      logic       pen_val;
      logic       rot_cw;
      logic       rot_ccw;
      logic       move_load;
      logic       move_jump;
      logic       mark_step;
      logic       base_rd;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       disp_start;
      logic       out_load;
      logic       out_disp;
      logic       out_err;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic steps_zero;
      logic steps_one;
      logic vertical;
      logic pen;
      logic disp_last;
      logic out_free;
   } stat_type;

endpackage

### sv/tpg_ctrl.sv
// Command sequencer of the turtle plotter grid block.
module tpg_ctrl import tpg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [REQ_USER_W-1:0] req_kind,
   output logic                  req_ready,
   output cmd_type               cmd,
   input  stat_type              stat
);

   state_type state_ff, state_in;
   logic      err_ff, err_in;
   logic      first_ff, first_in;
   logic      accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   // Hold the error flag of the accepted item and mark the first step of a walk.
   assign err_in   = accept ? !(req_kind == KIND_PEN_UP || req_kind == KIND_PEN_DOWN ||
                                req_kind == KIND_TURN_RIGHT || req_kind == KIND_TURN_LEFT ||
                                req_kind == KIND_MOVE || req_kind == KIND_DISPLAY)
                            : err_ff;
   assign first_in = (state_ff == ST_MV_READ);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         err_ff   <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
         first_ff <= first_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  KIND_MOVE: begin
                     state_in = (stat.pen && !stat.steps_zero) ? ST_MV_READ : ST_RESP;
                  end
                  KIND_DISPLAY: state_in = ST_DISP;
                  default:      state_in = ST_RESP;
               endcase
            end
         end
         ST_RESP: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         ST_MV_READ: state_in = ST_MV_STEP;
         ST_MV_STEP: begin
            if (stat.steps_one) state_in = ST_RESP;
         end
         ST_DISP: begin
            if (stat.out_free && stat.disp_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd       = '0;
      cmd.rd_sel = RD_ZERO;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_kind)
                  KIND_PEN_UP: begin
                     cmd.pen_set = 1'b1;
                     cmd.pen_val = 1'b0;
                  end
                  KIND_PEN_DOWN: begin
                     cmd.pen_set = 1'b1;
                     cmd.pen_val = 1'b1;
                  end
                  KIND_TURN_RIGHT: cmd.rot_cw  = 1'b1;
                  KIND_TURN_LEFT:  cmd.rot_ccw = 1'b1;
                  KIND_MOVE: begin
                     cmd.move_load = 1'b1;
                     cmd.move_jump = !stat.pen;
                  end
                  KIND_DISPLAY: begin
                     cmd.disp_start = 1'b1;
                     cmd.rd_en      = 1'b1;
                     cmd.rd_sel     = RD_ZERO;
                  end
                  default: ;
               endcase
            end
         end
         ST_RESP: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_err  = err_ff;
            end
         end
         ST_MV_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_CUR;
         end
         ST_MV_STEP: begin
            cmd.mark_step = 1'b1;
            cmd.base_rd   = first_ff || stat.vertical;
            if (stat.vertical && !stat.steps_one) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
            end
         end
         ST_DISP: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_disp = 1'b1;
               if (!stat.disp_last) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_DISP_NEXT;
               end
            end
         end
         default: ;
      endcase
   end

   // A result is loaded only into a free output register.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("result loaded into occupied output register");

   // Walking marks cells only with the pen down.
   a_walk_pen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MV_STEP) |-> stat.pen)
      else $error("marking walk with pen up");

   // The row fetch always leads straight into the first step.
   a_read_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MV_READ) |=> (state_ff == ST_MV_STEP))
      else $error("row fetch not followed by a step");

endmodule

### sv/tpg_datapath.sv
// Grid memory, turtle state and result register of the turtle plotter grid block.
module tpg_datapath import tpg_pkg::*; #(
   parameter int ROWS = 20,
   parameter int COLS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] move_count,
   input  cmd_type               cmd,
   output stat_type              stat,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLS);
   localparam int SW = (RW > CW) ? RW : CW;
   localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
   localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);

   logic [COLS-1:0]       grid_mem [ROWS];
   logic [ROWS-1:0]       row_valid_ff;
   logic [COLS-1:0]       rd_data_ff;
   logic                  rd_vld_ff;
   logic [COLS-1:0]       rd_row;
   logic [RW-1:0]         rd_addr;

   logic [RW-1:0]         cur_row_ff, cur_row_in;
   logic [CW-1:0]         cur_col_ff, cur_col_in;
   logic [1:0]            heading_ff, heading_in;
   logic                  pen_ff, pen_in;
   logic [SW-1:0]         steps_ff, steps_in;
   logic [RW-1:0]         disp_row_ff, disp_row_in;
   logic [COLS-1:0]       rowbuf_ff, rowbuf_in;

   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                  out_err_ff, out_err_in;
   logic                  out_last_ff, out_last_in;

   logic [SW-1:0]         room_ahead;
   logic [SW-1:0]         steps_c;
   logic [RW-1:0]         next_row;
   logic [COLS-1:0]       wrow;
   logic [ROW_BITS_W-1:0] row_out;
   logic                  disp_last;
   logic                  out_free;

   // Distance to the edge ahead, and the clipped walk length.
   always_comb begin
      case (heading_ff)
         HEAD_EAST:  room_ahead = SW'(COL_LAST) - SW'(cur_col_ff);
         HEAD_SOUTH: room_ahead = SW'(ROW_LAST) - SW'(cur_row_ff);
         HEAD_WEST:  room_ahead = SW'(cur_col_ff);
         default:    room_ahead = SW'(cur_row_ff);
      endcase
   end

   assign steps_c = (move_count < REQ_DATA_W'(room_ahead)) ? SW'(move_count) : room_ahead;

   // Select the grid row to read.
   assign next_row = (heading_ff == HEAD_SOUTH) ? cur_row_ff + RW'(1) : cur_row_ff - RW'(1);

   always_comb begin
      case (cmd.rd_sel)
         RD_CUR:       rd_addr = cur_row_ff;
         RD_NEXT:      rd_addr = next_row;
         RD_DISP_NEXT: rd_addr = disp_row_ff + RW'(1);
         default:      rd_addr = '0;
      endcase
   end

   // A row never written reads as cleared.
   assign rd_row = rd_vld_ff ? rd_data_ff : '0;
   assign wrow   = (cmd.base_rd ? rd_row : rowbuf_ff) | (COLS'(1) << cur_col_ff);

   // Grid memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.mark_step) grid_mem[cur_row_ff] <= wrow;
      if (cmd.rd_en) begin
         rd_data_ff <= grid_mem[rd_addr];
         rd_vld_ff  <= row_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) row_valid_ff <= '0;
      else if (cmd.mark_step) row_valid_ff[cur_row_ff] <= 1'b1;
   end

   // Turtle state updates.
   always_comb begin
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      if (cmd.move_jump) begin
         case (heading_ff)
            HEAD_EAST:  cur_col_in = cur_col_ff + CW'(steps_c);
            HEAD_SOUTH: cur_row_in = cur_row_ff + RW'(steps_c);
            HEAD_WEST:  cur_col_in = cur_col_ff - CW'(steps_c);
            default:    cur_row_in = cur_row_ff - RW'(steps_c);
         endcase
      end else if (cmd.mark_step) begin
         case (heading_ff)
            HEAD_EAST:  cur_col_in = cur_col_ff + CW'(1);
            HEAD_SOUTH: cur_row_in = cur_row_ff + RW'(1);
            HEAD_WEST:  cur_col_in = cur_col_ff - CW'(1);
            default:    cur_row_in = cur_row_ff - RW'(1);
         endcase
      end
   end

   always_comb begin
      heading_in = heading_ff;
      if (cmd.rot_cw)       heading_in = heading_ff + 2'd1;
      else if (cmd.rot_ccw) heading_in = heading_ff + 2'd3;
   end

   assign pen_in      = cmd.pen_set ? cmd.pen_val : pen_ff;
   assign steps_in    = cmd.move_load ? steps_c :
                        cmd.mark_step ? steps_ff - SW'(1) : steps_ff;
   assign rowbuf_in   = cmd.mark_step ? wrow : rowbuf_ff;
   assign disp_row_in = cmd.disp_start ? '0 :
                        (cmd.out_load && cmd.out_disp) ? disp_row_ff + RW'(1) : disp_row_ff;
   assign disp_last   = (disp_row_ff == ROW_LAST);

   // Fit a grid row to the result field.
   if (COLS >= ROW_BITS_W) begin : g_row_trunc
      assign row_out = rd_row[ROW_BITS_W-1:0];
   end else begin : g_row_ext
      assign row_out = {{(ROW_BITS_W - COLS){1'b0}}, rd_row};
   end

   // Result register: take a new item when empty or whenever the old one leaves.
   assign out_free     = !out_valid_ff || rsp_tready;
   assign out_valid_in = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   assign out_data_in  = cmd.out_load ?
                         {{RSP_PAD_W{1'b0}}, pen_ff, heading_ff,
                          POS_W'(cur_col_ff), POS_W'(cur_row_ff),
                          cmd.out_disp ? POS_W'(disp_row_ff) : POS_W'(0),
                          cmd.out_disp ? row_out : ROW_BITS_W'(0)} : out_data_ff;
   assign out_err_in   = cmd.out_load ? cmd.out_err : out_err_ff;
   assign out_last_in  = cmd.out_load ? (!cmd.out_disp || disp_last) : out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         heading_ff   <= HEAD_EAST;
         pen_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         heading_ff   <= heading_in;
         pen_ff       <= pen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff    <= steps_in;
      rowbuf_ff   <= rowbuf_in;
      disp_row_ff <= disp_row_in;
      out_data_ff <= out_data_in;
      out_err_ff  <= out_err_in;
      out_last_ff <= out_last_in;
   end

   assign stat.steps_zero = (steps_c == '0);
   assign stat.steps_one  = (steps_ff == SW'(1));
   assign stat.vertical   = (heading_ff == HEAD_SOUTH) || (heading_ff == HEAD_NORTH);
   assign stat.pen        = pen_ff;
   assign stat.disp_last  = disp_last;
   assign stat.out_free   = out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_err_ff;
   assign rsp_tlast  = out_last_ff;

   // The turtle stays on the grid.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (cur_row_ff <= ROW_LAST) && (cur_col_ff <= COL_LAST))
      else $error("turtle position off the grid");

   // Every marking step has a cell left to walk.
   a_step_count: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_step |-> (steps_ff != '0) && pen_ff)
      else $error("marking step with no walk pending");

   // The final display row closes the command.
   a_disp_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && cmd.out_disp && disp_last) |=> (rsp_tvalid && rsp_tlast))
      else $error("final display row without last");

endmodule

### sv/turtle_plotter_grid.sv
// Top level of the turtle plotter grid block.
//
// Request channel (req_): one item is one command; req_tuser holds the kind
// (pen up, pen down, turn right, turn left, move, display), req_tdata the
// move count. Result channel (rsp_): tdata holds the grid row, its index and
// the turtle's position, heading and pen; tuser flags an invalid kind; tlast
// marks the final result of a command.
// Display returns one result per grid row, rows in order; every other command
// returns one result. Commands are worked one at a time by a sequencer over a
// grid memory with one write port and one registered read port.
// Pen, turn, invalid kinds and pen-up or zero-distance moves go straight to the
// result; a pen-down move fetches its row, then walks one cell per cycle on the
// memory write port; display, while the receiver is ready, returns one row per
// cycle on the memory read port.
// The result register frees the request side: the next command is taken while
// a result still waits. A stalled receiver holds the sequencer before it
// loads its next result.
// Reset (synchronous, active high) clears the grid, puts the turtle at row 0,
// column 0, facing east with the pen up, and empties the result register.
module turtle_plotter_grid import tpg_pkg::*; #(
   parameter int ROWS = 20,
   parameter int COLS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] move_count
   input  logic [REQ_USER_W-1:0] req_tuser,  // [2:0] kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [19:0] row_bits, [24:20] row_index,
                                             // [29:25] pos_row, [34:30] pos_col,
                                             // [36:35] heading, [37] pen_down, [39:38] zero
   output logic                  rsp_tuser,  // [0] status
   output logic                  rsp_tlast
);

   cmd_type  cmd;
   stat_type stat;

   // Sequence each command.
   tpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .req_ready (req_tready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Hold the grid, the turtle and the result register.
   tpg_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .move_count (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
